// File: rtl/mcsw_pkg.sv
// ============================================================================
// mcsw_pkg
// Shared types and constants of the multicore stall watchdog monitor.
// ============================================================================
package mcsw_pkg;

    localparam int STAMP_W     = 32;
    localparam int NUM_CPUS_DEF = 4;

    // Event codes on the input mode field.
    localparam logic [1:0] MODE_SOFT   = 2'd0;
    localparam logic [1:0] MODE_HARD   = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_STALL = 2'd0;
    localparam logic [1:0] CFG_CORE_SIZE = 2'd1;
    localparam logic [1:0] CFG_HOME_CPU  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] DEF_MAX_STALL_MS  = 32'd10000;
    localparam logic [2:0]  DEF_CPUS_PER_CORE = 3'd2;
    localparam logic [1:0]  DEF_HOME_CPU      = 2'd0;

    // Control of the stamp store.
    typedef struct packed {
        logic rd;       // read both stamps at the read address
        logic soft_we;  // write the soft stamp at the write address
        logic hard_we;  // write the hard stamp at the write address
        logic clear;    // forget every stamp (they read as zero)
    } t_store_ctl;

endpackage

// File: rtl/mcsw_in_if.sv
// ============================================================================
// mcsw_in_if
// Event channel: valid/ready handshake carrying one heartbeat or expiry.
// ============================================================================
interface mcsw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  cpu;
    logic [31:0] now_ms;

    modport source (output valid, output mode, output cpu, output now_ms, input ready);
    modport sink   (input valid, input mode, input cpu, input now_ms, output ready);
endinterface

// File: rtl/mcsw_out_if.sv
// ============================================================================
// mcsw_out_if
// Result channel: valid/ready handshake carrying one result per event.
// ============================================================================
interface mcsw_out_if;
    logic        valid;
    logic        ready;
    logic        restart_timers;
    logic        rebound;
    logic [1:0]  irq_cpu;
    logic [1:0]  worst_cpu;
    logic [31:0] worst_period;
    logic [3:0]  soft_stalled_mask;
    logic [3:0]  hard_stalled_mask;
    logic        stopped;

    modport source (
        output valid, output restart_timers, output rebound, output irq_cpu,
        output worst_cpu, output worst_period, output soft_stalled_mask,
        output hard_stalled_mask, output stopped, input ready
    );
    modport sink (
        input valid, input restart_timers, input rebound, input irq_cpu,
        input worst_cpu, input worst_period, input soft_stalled_mask,
        input hard_stalled_mask, input stopped, output ready
    );
endinterface

// File: rtl/multicore_stall_watchdog_monitor_core.sv
// ============================================================================
// multicore_stall_watchdog_monitor_core
// Per-CPU heartbeat watchdog monitor with interrupt steering.
// ============================================================================
// Events enter on i_in (valid/ready); each transfer carries an event kind, the
// reporting CPU and the watchdog time in ms. Every event yields exactly one
// result transfer on o_out. The user must write configuration (i_cfg_we,
// i_cfg_idx, i_cfg_data) only while idle; the block does not enforce it.
//
// One event is processed at a time, and i_in.ready is high only while idle.
// A soft heartbeat, an ignored event or any event after stop goes straight
// to its result. A hard heartbeat sweeps the soft stamp RAM one entry a
// cycle; when it finds a stall it then sweeps the hard stamps of the threads
// of the stalled CPU's core below NUM_CPUS. An expiry event sweeps the first
// min(NUM_CPUS, 4) entries of both RAMs in parallel. The next event can be
// taken in the same cycle in which the result is offered on o_out.
// Each stamp RAM has a single read port, so a sweep reads one entry at a time.
//
// Reset clears the alive mask, the stop flag and all stamp valid bits, so
// every stamp reads as zero with no clearing pass. A result waits in the
// output register while the receiver stalls; the next event is still taken,
// and its result is held back until the output register is free.
// ============================================================================
module multicore_stall_watchdog_monitor_core
    import mcsw_pkg::*;
#(
    parameter int NUM_CPUS = NUM_CPUS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcsw_in_if.sink     i_in,
    mcsw_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Index width of the stamp RAMs, and a scan counter wide enough to run
    // past the last CPU by a whole core.
    localparam int IW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SW    = $clog2(NUM_CPUS + 8);
    localparam int EXP_N = (NUM_CPUS < 4) ? NUM_CPUS : 4;
    localparam logic [SW-1:0] N_SW   = SW'(NUM_CPUS);
    localparam logic [SW-1:0] EXP_SW = SW'(EXP_N);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SOFT_SCAN,
        S_CORE_SCAN,
        S_EXPIRY_SCAN,
        S_FINISH
    } t_state;

    // A stamp is overdue when stamp plus limit, modulo 2^32, lies below now.
    function automatic logic over_limit(input logic [31:0] stamp,
                                        input logic [31:0] limit,
                                        input logic [31:0] now);
        logic [31:0] sum;
        sum = stamp + limit;
        return sum < now;
    endfunction

    t_state r_state;

    // Event being processed.
    logic [1:0]          r_mode;
    logic [1:0]          r_cpu;
    logic [31:0]         r_now;

    // Configuration and architectural state.
    logic [31:0]         r_max;
    logic [2:0]          r_cpc;
    logic [NUM_CPUS-1:0] r_alive;
    logic [1:0]          r_target;
    logic                r_halted;

    // Sweep control: issue side and the read returning in the cycle after issue.
    logic [SW-1:0]       r_iss;
    logic [2:0]          r_off;
    logic [IW-1:0]       r_base;
    logic                r_ret_vld;
    logic [IW-1:0]       r_ret_idx;
    logic [IW-1:0]       r_ret_base;

    // Working results.
    logic [31:0]         r_pmax;
    logic [IW-1:0]       r_worst;
    logic [IW-1:0]       r_wbase;
    logic                r_found;
    logic [1:0]          r_pick;
    logic                r_restart;
    logic                r_rebound;
    logic [3:0]          r_smask;
    logic [3:0]          r_hmask;

    // Output register.
    logic                r_o_valid;
    logic                r_o_restart;
    logic                r_o_rebound;
    logic [1:0]          r_o_irq;
    logic [1:0]          r_o_worst;
    logic [31:0]         r_o_period;
    logic [3:0]          r_o_smask;
    logic [3:0]          r_o_hmask;
    logic                r_o_stopped;

    t_store_ctl          w_ctl;
    logic [STAMP_W-1:0]  w_soft_q;
    logic [STAMP_W-1:0]  w_hard_q;
    logic [2:0]          w_size;
    logic                w_issue;
    logic                w_cpu_ok;
    logic [NUM_CPUS-1:0] w_alive_next;
    logic [31:0]         w_period;

    // A core size of zero counts as one thread per core.
    assign w_size   = (r_cpc == 3'd0) ? 3'd1 : r_cpc;
    assign w_cpu_ok = 32'(r_cpu) < NUM_CPUS;
    assign w_period = r_now - w_soft_q;

    always_comb begin
        w_alive_next = r_alive;
        if (w_cpu_ok) begin
            w_alive_next[IW'(r_cpu)] = 1'b1;
        end
    end

    // Whether the current sweep reads another entry this cycle.
    always_comb begin
        unique case (r_state)
            S_SOFT_SCAN:   w_issue = r_iss < N_SW;
            S_CORE_SCAN:   w_issue = (r_off < w_size) && (r_iss < N_SW);
            S_EXPIRY_SCAN: w_issue = r_iss < EXP_SW;
            default:       w_issue = 1'b0;
        endcase
    end

    always_comb begin
        w_ctl         = '0;
        w_ctl.rd      = w_issue;
        if (r_state == S_DISPATCH && !r_halted && w_cpu_ok) begin
            if (r_mode == MODE_SOFT) begin
                w_ctl.clear   = &w_alive_next;
                w_ctl.soft_we = ~&w_alive_next;
            end else if (r_mode == MODE_HARD) begin
                w_ctl.hard_we = 1'b1;
            end
        end
    end

    mcsw_stamp_store #(.NUM_CPUS(NUM_CPUS)) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_raddr  (r_iss[IW-1:0]),
        .i_waddr  (IW'(r_cpu)),
        .i_wdata  (r_now),
        .o_soft_q (w_soft_q),
        .o_hard_q (w_hard_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max     <= DEF_MAX_STALL_MS;
            r_cpc     <= DEF_CPUS_PER_CORE;
            r_target  <= DEF_HOME_CPU;
            r_alive   <= '0;
            r_halted  <= 1'b0;
            r_ret_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_STALL: r_max    <= i_cfg_data;
                    CFG_CORE_SIZE: r_cpc    <= i_cfg_data[2:0];
                    CFG_HOME_CPU:  r_target <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            r_ret_vld  <= w_issue;
            r_ret_idx  <= r_iss[IW-1:0];
            r_ret_base <= r_base;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= i_in.mode;
                        r_cpu   <= i_in.cpu;
                        r_now   <= i_in.now_ms;
                        r_state <= S_DISPATCH;
                    end
                end

                S_DISPATCH: begin
                    r_restart <= 1'b0;
                    r_rebound <= 1'b0;
                    r_smask   <= '0;
                    r_hmask   <= '0;
                    r_pmax    <= '0;
                    r_worst   <= '0;
                    r_wbase   <= '0;
                    r_found   <= 1'b0;
                    r_pick    <= r_cpu;
                    r_iss     <= '0;
                    r_off     <= '0;
                    r_base    <= '0;
                    r_state   <= S_FINISH;
                    if (!r_halted) begin
                        unique case (r_mode)
                            MODE_SOFT: begin
                                if (w_cpu_ok) begin
                                    if (&w_alive_next) begin
                                        r_alive   <= '0;
                                        r_restart <= 1'b1;
                                    end else begin
                                        r_alive <= w_alive_next;
                                    end
                                end
                            end
                            MODE_HARD: begin
                                if (w_cpu_ok) begin
                                    r_state <= S_SOFT_SCAN;
                                end
                            end
                            MODE_EXPIRE: begin
                                r_halted <= 1'b1;
                                r_state  <= S_EXPIRY_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end

                S_SOFT_SCAN: begin
                    // Track the first CPU of each core alongside the issue
                    // index, so the core of the worst CPU is known without
                    // dividing by the core size.
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                        if (r_off + 3'd1 == w_size) begin
                            r_off  <= '0;
                            r_base <= IW'(r_iss + 1'b1);
                        end else begin
                            r_off <= r_off + 3'd1;
                        end
                    end
                    if (r_ret_vld && (32'(r_ret_idx) != 32'(r_cpu))
                            && (r_pmax < w_period)) begin
                        r_pmax  <= w_period;
                        r_worst <= r_ret_idx;
                        r_wbase <= r_ret_base;
                    end
                    if (!w_issue && !r_ret_vld) begin
                        if (r_pmax > r_max) begin
                            r_iss   <= SW'(r_wbase);
                            r_off   <= '0;
                            r_state <= S_CORE_SCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end

                S_CORE_SCAN: begin
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                        r_off <= r_off + 3'd1;
                    end
                    if (r_ret_vld && !r_found && !over_limit(w_hard_q, r_max, r_now)) begin
                        r_found <= 1'b1;
                        r_pick  <= 2'(r_ret_idx);
                    end
                    if (!w_issue && !r_ret_vld) begin
                        if (r_pick != r_target) begin
                            r_target  <= r_pick;
                            r_rebound <= 1'b1;
                        end
                        r_state <= S_FINISH;
                    end
                end

                S_EXPIRY_SCAN: begin
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (r_ret_vld) begin
                        if (over_limit(w_soft_q, r_max, r_now)) begin
                            r_smask[2'(r_ret_idx)] <= 1'b1;
                        end
                        if (over_limit(w_hard_q, r_max, r_now)) begin
                            r_hmask[2'(r_ret_idx)] <= 1'b1;
                        end
                    end
                    if (!w_issue && !r_ret_vld) begin
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_restart <= r_restart;
                        r_o_rebound <= r_rebound;
                        r_o_irq     <= r_target;
                        r_o_worst   <= 2'(r_worst);
                        r_o_period  <= r_pmax;
                        r_o_smask   <= r_smask;
                        r_o_hmask   <= r_hmask;
                        r_o_stopped <= r_halted;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_o_valid;
    assign o_out.restart_timers    = r_o_restart;
    assign o_out.rebound           = r_o_rebound;
    assign o_out.irq_cpu           = r_o_irq;
    assign o_out.worst_cpu         = r_o_worst;
    assign o_out.worst_period      = r_o_period;
    assign o_out.soft_stalled_mask = r_o_smask;
    assign o_out.hard_stalled_mask = r_o_hmask;
    assign o_out.stopped           = r_o_stopped;

endmodule

// File: rtl/mcsw_ram.sv
// ============================================================================
// mcsw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module mcsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mcsw_stamp_store.sv
// ============================================================================
// mcsw_stamp_store
// Soft and hard heartbeat stamps in two RAMs, with per-entry valid bits so
// that a stamp never written since reset or restart reads as zero.
// ============================================================================
module mcsw_stamp_store
    import mcsw_pkg::*;
#(
    parameter int NUM_CPUS = NUM_CPUS_DEF,
    localparam int IW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_store_ctl         i_ctl,
    input  logic [IW-1:0]      i_raddr,
    input  logic [IW-1:0]      i_waddr,
    input  logic [STAMP_W-1:0] i_wdata,
    output logic [STAMP_W-1:0] o_soft_q,
    output logic [STAMP_W-1:0] o_hard_q
);

    logic [NUM_CPUS-1:0] r_soft_vld;
    logic [NUM_CPUS-1:0] r_hard_vld;
    logic                r_soft_qv;
    logic                r_hard_qv;
    logic [STAMP_W-1:0]  w_soft_ram_q;
    logic [STAMP_W-1:0]  w_hard_ram_q;

    mcsw_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_CPUS)) u_soft_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.soft_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_ctl.rd),
        .i_raddr (i_raddr),
        .o_rdata (w_soft_ram_q)
    );

    mcsw_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_CPUS)) u_hard_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.hard_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_ctl.rd),
        .i_raddr (i_raddr),
        .o_rdata (w_hard_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft_vld <= '0;
            r_hard_vld <= '0;
            r_soft_qv  <= 1'b0;
            r_hard_qv  <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_soft_vld <= '0;
                r_hard_vld <= '0;
            end else begin
                if (i_ctl.soft_we) begin
                    r_soft_vld[i_waddr] <= 1'b1;
                end
                if (i_ctl.hard_we) begin
                    r_hard_vld[i_waddr] <= 1'b1;
                end
            end
            if (i_ctl.rd) begin
                r_soft_qv <= r_soft_vld[i_raddr];
                r_hard_qv <= r_hard_vld[i_raddr];
            end
        end
    end

    assign o_soft_q = r_soft_qv ? w_soft_ram_q : '0;
    assign o_hard_q = r_hard_qv ? w_hard_ram_q : '0;

endmodule

// File: sim/tb_multicore_stall_watchdog_monitor_core.sv
// ============================================================================
// tb_multicore_stall_watchdog_monitor_core
// Self-checking bench for the per-CPU heartbeat watchdog monitor.
// ============================================================================
// A short table of hand-picked events runs first. Its first rows carry
// results typed in by hand, and every other row is checked against a
// behavioural model of the monitor held in this module. Twelve phases of
// random heartbeats follow, each under its own register settings. A stop
// sequence closes the run, because an expiry event halts the block for good
// and reset is applied only once. Both channels idle at random between
// transfers, with calm phases in which neither side holds back.
// ============================================================================
module tb_multicore_stall_watchdog_monitor_core;
    import mcsw_pkg::*;

    localparam int NUM_CPUS    = NUM_CPUS_DEF;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 50;
    // Cycles with no transfer on either channel before the run is abandoned.
    // The slowest correct gap is a sender pause, a hard heartbeat sweep and
    // a receiver stall back to back.
    localparam int STALL_LIMIT = 400;
    // A hard heartbeat that finds a stall is the slowest event to offer its
    // result after its transfer.
    localparam int TAIL_CYCLES = 30;

    // Mode code that the block ignores, and a register index with no register.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic        restart_timers;
        logic        rebound;
        logic [1:0]  irq_cpu;
        logic [1:0]  worst_cpu;
        logic [31:0] worst_period;
        logic [3:0]  soft_stalled_mask;
        logic [3:0]  hard_stalled_mask;
        logic        stopped;
    } watch_result_t;

    typedef struct packed {
        logic [1:0]    mode;
        logic [1:0]    cpu;
        logic [31:0]   now_ms;
        logic          fixed;   // the result below is the one to expect
        watch_result_t want;
    } stim_row_t;

    localparam watch_result_t RESULT_IDLE = '0;
    // After stop with the interrupt left on CPU 3 by the last home write.
    localparam watch_result_t RESULT_STOPPED_ON_3 =
        '{irq_cpu: 2'd3, stopped: 1'b1, default: '0};

    // Opening rows run under the reset settings: limit 10000 ms, two threads
    // per core, interrupt on CPU 0.
    localparam stim_row_t OPENING_ROWS [16] = '{
        '{MODE_SOFT,   2'd0, 32'h0000_0000, 1'b1, RESULT_IDLE},
        '{MODE_HARD,   2'd0, 32'h0000_0000, 1'b1, RESULT_IDLE},
        '{MODE_UNUSED, 2'd3, 32'hFFFF_FFFF, 1'b1, RESULT_IDLE},
        '{MODE_SOFT,   2'd1, 32'd100,       1'b0, RESULT_IDLE},
        '{MODE_SOFT,   2'd2, 32'd200,       1'b0, RESULT_IDLE},
        '{MODE_HARD,   2'd3, 32'd5000,      1'b0, RESULT_IDLE},
        // Every thread of the stalled core is hard stalled as well, so the
        // interrupt falls back to the CPU that reported.
        '{MODE_HARD,   2'd2, 32'hFFFF_FFFF, 1'b0, RESULT_IDLE},
        // Fourth CPU checks in: the watchdog restarts.
        '{MODE_SOFT,   2'd3, 32'd300,       1'b0, RESULT_IDLE},
        '{MODE_HARD,   2'd1, 32'd20000,     1'b0, RESULT_IDLE},
        // A period equal to the limit is not a stall; one more ms is.
        '{MODE_HARD,   2'd0, 32'd10000,     1'b0, RESULT_IDLE},
        '{MODE_HARD,   2'd0, 32'd10001,     1'b0, RESULT_IDLE},
        '{MODE_SOFT,   2'd3, 32'h8000_0000, 1'b0, RESULT_IDLE},
        // The difference wraps modulo 2^32.
        '{MODE_HARD,   2'd2, 32'h7FFF_FFFF, 1'b0, RESULT_IDLE},
        '{MODE_SOFT,   2'd0, 32'hFFFF_FFFF, 1'b0, RESULT_IDLE},
        '{MODE_HARD,   2'd3, 32'hFFFF_FFFF, 1'b0, RESULT_IDLE},
        '{MODE_UNUSED, 2'd0, 32'h0000_0000, 1'b0, RESULT_IDLE}
    };

    // Closing rows: a couple of heartbeats, the one expiry of the run, and
    // then one event of every kind, all of which the halted block ignores.
    localparam stim_row_t CLOSING_ROWS [7] = '{
        '{MODE_SOFT,   2'd0, 32'd5000,      1'b0, RESULT_IDLE},
        '{MODE_SOFT,   2'd1, 32'd4000,      1'b0, RESULT_IDLE},
        '{MODE_EXPIRE, 2'd2, 32'd5500,      1'b0, RESULT_IDLE},
        '{MODE_SOFT,   2'd3, 32'h0000_0000, 1'b1, RESULT_STOPPED_ON_3},
        '{MODE_HARD,   2'd1, 32'hFFFF_FFFF, 1'b1, RESULT_STOPPED_ON_3},
        '{MODE_EXPIRE, 2'd0, 32'hFFFF_FFFF, 1'b1, RESULT_STOPPED_ON_3},
        '{MODE_UNUSED, 2'd2, 32'h0000_0000, 1'b1, RESULT_STOPPED_ON_3}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    mcsw_in_if  beat_ch ();
    mcsw_out_if report_ch ();

    multicore_stall_watchdog_monitor_core #(
        .NUM_CPUS (NUM_CPUS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (beat_ch),
        .o_out      (report_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Model of the monitor: registers and state as the block should hold them.
    logic [31:0] stall_limit;
    logic [2:0]  core_size;
    logic [1:0]  irq_target;
    logic [31:0] soft_ms [NUM_CPUS];
    logic [31:0] hard_ms [NUM_CPUS];
    logic [3:0]  alive_cpus;
    logic        halted;

    // Results still owed by the block, oldest first.
    watch_result_t pending_results [$];

    bit          calm;
    logic [31:0] clock_ms;
    int          mismatches;
    int          results_checked;
    int          events_sent;
    int          restarts_seen;
    int          rebounds_seen;
    int          settings_used;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic void clear_model();
        int i;
        stall_limit = DEF_MAX_STALL_MS;
        core_size   = DEF_CPUS_PER_CORE;
        irq_target  = DEF_HOME_CPU;
        for (i = 0; i < NUM_CPUS; i++) begin
            soft_ms[i] = '0;
            hard_ms[i] = '0;
        end
        alive_cpus = '0;
        halted     = 1'b0;
    endfunction

    function automatic void load_register(logic [1:0] idx, logic [31:0] data);
        case (idx)
            CFG_MAX_STALL: stall_limit = data;
            CFG_CORE_SIZE: core_size = data[2:0];
            // A new home CPU takes the interrupt at once.
            CFG_HOME_CPU:  irq_target = data[1:0];
            default: ;
        endcase
    endfunction

    // Applies one event to the model and returns the result it should cause.
    function automatic watch_result_t step_watchdog(logic [1:0] mode, logic [1:0] cpu,
                                                    logic [31:0] now);
        watch_result_t r;
        logic [31:0]   period;
        int            i;
        int            size;
        int            lo;
        int            pick;
        bit            found;
        r = '0;
        if (!halted && mode == MODE_SOFT && int'(cpu) < NUM_CPUS) begin
            alive_cpus = alive_cpus | (4'b0001 << cpu);
            if (alive_cpus == 4'hF) begin
                // Everyone has checked in: start a fresh watchdog period.
                alive_cpus       = '0;
                r.restart_timers = 1'b1;
                for (i = 0; i < NUM_CPUS; i++) begin
                    soft_ms[i] = '0;
                    hard_ms[i] = '0;
                end
            end else begin
                soft_ms[cpu] = now;
            end
        end else if (!halted && mode == MODE_HARD && int'(cpu) < NUM_CPUS) begin
            hard_ms[cpu] = now;
            // Longest soft silence among the other CPUs; the first one wins ties.
            for (i = 0; i < NUM_CPUS; i++) begin
                if (i != int'(cpu)) begin
                    period = now - soft_ms[i];
                    if (r.worst_period < period) begin
                        r.worst_period = period;
                        r.worst_cpu    = 2'(i);
                    end
                end
            end
            if (r.worst_period > stall_limit) begin
                // Steer to the first thread of that core that is not hard
                // stalled, skipping slots past the last CPU.
                size  = (core_size == 3'd0) ? 1 : int'(core_size);
                lo    = (int'(r.worst_cpu) / size) * size;
                pick  = int'(cpu);
                found = 1'b0;
                for (i = lo; i < lo + size && i < NUM_CPUS; i++) begin
                    if (!found && !(hard_ms[i] + stall_limit < now)) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (2'(pick) != irq_target) begin
                    irq_target = 2'(pick);
                    r.rebound  = 1'b1;
                end
            end
        end else if (!halted && mode == MODE_EXPIRE) begin
            halted = 1'b1;
            for (i = 0; i < NUM_CPUS && i < 4; i++) begin
                r.soft_stalled_mask[i] = (soft_ms[i] + stall_limit < now);
                r.hard_stalled_mask[i] = (hard_ms[i] + stall_limit < now);
            end
        end
        r.irq_cpu = irq_target;
        r.stopped = halted;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Offers one event, waits for its transfer and files the result it owes.
    // A fixed row files its typed result instead, though the model still
    // takes the event so that its state keeps step with the block.
    task automatic send_event(input logic [1:0] mode, input logic [1:0] cpu,
                              input logic [31:0] now, input logic fixed,
                              input watch_result_t want, output watch_result_t modelled);
        int gap;
        beat_ch.valid  <= 1'b1;
        beat_ch.mode   <= mode;
        beat_ch.cpu    <= cpu;
        beat_ch.now_ms <= now;
        do @(posedge i_clk); while (!beat_ch.ready);
        modelled = step_watchdog(mode, cpu, now);
        pending_results.push_back(fixed ? want : modelled);
        events_sent++;
        restarts_seen += int'(modelled.restart_timers);
        rebounds_seen += int'(modelled.rebound);
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            beat_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Withdraws the event channel and waits until every result has come back.
    task automatic wait_drained();
        beat_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One register write per clock edge; the caller drops the write enable
    // once its batch is done.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        load_register(idx, data);
    endtask

    task automatic run_random_phase(input int phase);
        logic [31:0]   limit;
        logic [31:0]   step_span;
        logic [31:0]   now;
        logic [1:0]    home;
        logic [1:0]    mode;
        logic [1:0]    cpu;
        logic [1:0]    lazy_soft;
        logic [1:0]    lazy_hard;
        watch_result_t modelled;
        int            counted;
        int            roll;
        case (phase % 5)
            0:       limit = 32'd1;
            1:       limit = 32'hFFFF_FFFF;
            2:       limit = DEF_MAX_STALL_MS;
            3:       limit = $urandom_range(2, 3000);
            default: limit = $urandom;
        endcase
        home = (phase < 4) ? 2'(3 - phase) : 2'($urandom_range(0, 3));

        wait_drained();
        // The spare index must leave every register as it was.
        if (phase == 5)
            write_register(CFG_UNUSED, $urandom);
        write_register(CFG_MAX_STALL, limit);
        write_register(CFG_CORE_SIZE, 32'(phase % 8));
        write_register(CFG_HOME_CPU, 32'(home));
        cfg_we <= 1'b0;
        settings_used++;

        calm = (phase % 3 == 2);
        // One CPU rarely sends soft heartbeats and one rarely sends hard ones,
        // so that stalls build up and steering has work to do.
        lazy_soft = 2'($urandom_range(0, 3));
        lazy_hard = 2'($urandom_range(0, 3));
        step_span = (limit > 32'd30000) ? 32'd10000 : limit / 3 + 1;
        counted   = 0;
        while (counted < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                // Noise: ignored mode codes, or heartbeats at any time at all.
                mode = ($urandom_range(0, 1) != 0) ? MODE_UNUSED
                                                   : 2'($urandom_range(0, 1));
                cpu  = 2'($urandom_range(0, 3));
                now  = $urandom;
            end else begin
                if (roll < 14)
                    clock_ms += limit + $urandom_range(1, 2000);
                else
                    clock_ms += $urandom_range(0, step_span);
                mode = ($urandom_range(0, 1) != 0) ? MODE_HARD : MODE_SOFT;
                cpu  = 2'($urandom_range(0, 3));
                if (mode == MODE_SOFT && cpu == lazy_soft && $urandom_range(0, 3) != 0)
                    cpu = cpu + 2'd1;
                if (mode == MODE_HARD && cpu == lazy_hard && $urandom_range(0, 3) != 0)
                    cpu = cpu + 2'd1;
                now = clock_ms;
            end
            send_event(mode, cpu, now, 1'b0, RESULT_IDLE, modelled);
            if (mode != MODE_UNUSED)
                counted++;
            // A restart sets the watchdog clock back near zero.
            if (modelled.restart_timers)
                clock_ms = $urandom_range(0, 64);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: after each result transfer, ready may drop at random; in a calm phase it stays high.
    // ------------------------------------------------------------------------
    int sink_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            report_ch.ready <= 1'b0;
            sink_hold = 0;
        end else if (!report_ch.ready) begin
            if (sink_hold == 0)
                report_ch.ready <= 1'b1;
            else
                sink_hold--;
        end else if (report_ch.valid) begin
            sink_hold = calm ? 0 : $urandom_range(0, 10);
            if (sink_hold != 0) begin
                report_ch.ready <= 1'b0;
                sink_hold--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s is %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        watch_result_t due;
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with no event outstanding");
            end else begin
                due = pending_results.pop_front();
                check_field("restart_timers",    32'(report_ch.restart_timers),
                            32'(due.restart_timers));
                check_field("rebound",           32'(report_ch.rebound), 32'(due.rebound));
                check_field("irq_cpu",           32'(report_ch.irq_cpu), 32'(due.irq_cpu));
                check_field("worst_cpu",         32'(report_ch.worst_cpu), 32'(due.worst_cpu));
                check_field("worst_period",      report_ch.worst_period, due.worst_period);
                check_field("soft_stalled_mask", 32'(report_ch.soft_stalled_mask),
                            32'(due.soft_stalled_mask));
                check_field("hard_stalled_mask", 32'(report_ch.hard_stalled_mask),
                            32'(due.hard_stalled_mask));
                check_field("stopped",           32'(report_ch.stopped), 32'(due.stopped));
            end
            results_checked++;
        end
    end

    // A run in which nothing moves for too long is a failure.
    int quiet_cycles;

    always @(posedge i_clk) begin
        if ((beat_ch.valid && beat_ch.ready) || (report_ch.valid && report_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("multicore_stall_watchdog_monitor_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        int            row;
        int            phase;
        watch_result_t modelled;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        beat_ch.valid    = 1'b0;
        beat_ch.mode     = MODE_SOFT;
        beat_ch.cpu      = '0;
        beat_ch.now_ms   = '0;
        report_ch.ready  = 1'b0;
        calm             = 1'b0;
        clock_ms         = '0;
        mismatches       = 0;
        results_checked  = 0;
        events_sent      = 0;
        restarts_seen    = 0;
        rebounds_seen    = 0;
        settings_used    = 1;
        quiet_cycles     = 0;
        clear_model();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < $size(OPENING_ROWS); row++)
            send_event(OPENING_ROWS[row].mode, OPENING_ROWS[row].cpu,
                       OPENING_ROWS[row].now_ms, OPENING_ROWS[row].fixed,
                       OPENING_ROWS[row].want, modelled);

        clock_ms = $urandom_range(0, 100);
        for (phase = 0; phase < PHASES; phase++)
            run_random_phase(phase);

        // Known settings for the stop sequence; the home write parks the
        // interrupt on CPU 3, which the rows after stop rely on.
        wait_drained();
        write_register(CFG_MAX_STALL, 32'd1000);
        write_register(CFG_CORE_SIZE, 32'd4);
        write_register(CFG_HOME_CPU, 32'd3);
        cfg_we <= 1'b0;
        settings_used++;
        calm = 1'b0;
        for (row = 0; row < $size(CLOSING_ROWS); row++)
            send_event(CLOSING_ROWS[row].mode, CLOSING_ROWS[row].cpu,
                       CLOSING_ROWS[row].now_ms, CLOSING_ROWS[row].fixed,
                       CLOSING_ROWS[row].want, modelled);

        wait_drained();
        // Any stray result would show up within the longest event latency.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d events under %0d register settings: %0d restarts, %0d moves of the interrupt.",
                 events_sent, settings_used, restarts_seen, rebounds_seen);
        $display("The run ended with an expiry and events offered to the stopped block; %0d results compared.",
                 results_checked);
        if (mismatches == 0)
            $display("multicore_stall_watchdog_monitor_core: match");
        else
            $display("multicore_stall_watchdog_monitor_core: mismatch");
        $finish;
    end

endmodule
